/* design/sorted_table_binary_search_macros.svh */
// Assertion macros used by the sorted table search datapath.
// Needs a clock named clock and a synchronous reset named reset in scope.
`ifndef SORTED_TABLE_BINARY_SEARCH_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define STBS_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("stbs assertion failed");

// Next-cycle implication, disabled in reset.
`define STBS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("stbs assertion failed");

`endif

/* design/stbs_pkg.sv */
// Types, codes and the control program of the sorted table search block.
// No dependencies.
package stbs_pkg;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_LOOKUP = 1'b1
   } opcode_type;

   typedef struct packed {
      logic        opcode;
      logic [7:0]  entry_index;
      logic [15:0] key;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [7:0] position;
      logic [3:0] probe_count;
   } rsp_type;

   localparam int COUNT_WIDTH = 9;
   localparam int SPAN_WIDTH  = 10;
   localparam logic [3:0] MAX_PROBES = 4'd9;

   typedef logic [1:0] step_type;

   localparam step_type STEP_FETCH   = 2'd0;
   localparam step_type STEP_TEST    = 2'd1;
   localparam step_type STEP_COMPARE = 2'd2;
   localparam step_type STEP_DONE    = 2'd3;

   typedef enum logic [2:0] {
      COND_NEVER    = 3'd0,
      COND_LOOKUP   = 3'd1,
      COND_EXHAUST  = 3'd2,
      COND_MATCH    = 3'd3,
      COND_OUT_FREE = 3'd4
   } cond_type;

   typedef struct packed {
      logic     req_ready;
      logic     load;
      logic     read;
      logic     compare;
      logic     finish;
      cond_type cond;
      step_type branch;
      step_type next;
   } ctrl_type;

   typedef struct packed {
      logic lookup;
      logic exhaust;
      logic match;
      logic out_free;
   } status_type;

   function automatic ctrl_type program_word(step_type step);
      ctrl_type word;
      word = '{req_ready: 1'b0, load: 1'b0, read: 1'b0, compare: 1'b0, finish: 1'b0,
               cond: COND_NEVER, branch: STEP_FETCH, next: STEP_FETCH};
      case (step)
         STEP_FETCH: begin
            word.req_ready = 1'b1;
            word.load      = 1'b1;
            word.cond      = COND_LOOKUP;
            word.branch    = STEP_TEST;
            word.next      = STEP_FETCH;
         end
         STEP_TEST: begin
            word.read   = 1'b1;
            word.cond   = COND_EXHAUST;
            word.branch = STEP_DONE;
            word.next   = STEP_COMPARE;
         end
         STEP_COMPARE: begin
            word.compare = 1'b1;
            word.cond    = COND_MATCH;
            word.branch  = STEP_DONE;
            word.next    = STEP_TEST;
         end
         STEP_DONE: begin
            word.finish = 1'b1;
            word.cond   = COND_OUT_FREE;
            word.branch = STEP_FETCH;
            word.next   = STEP_DONE;
         end
         default: begin
            word.next = STEP_FETCH;
         end
      endcase
      return word;
   endfunction

endpackage

/* design/stbs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stbs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/stbs_seq.sv */
// Microcode sequencer: step counter, control program and conditional jumps.
// Depends on stbs_pkg.
module stbs_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  stbs_pkg::status_type   status,
   output stbs_pkg::ctrl_type     ctrl
);
   import stbs_pkg::*;

   step_type step_ff;
   step_type step_in;
   ctrl_type word;
   logic     taken;

   assign word = program_word(step_ff);

   always_comb begin
      case (word.cond)
         COND_LOOKUP:   taken = status.lookup;
         COND_EXHAUST:  taken = status.exhaust;
         COND_MATCH:    taken = status.match;
         COND_OUT_FREE: taken = status.out_free;
         default:       taken = 1'b0;
      endcase
      step_in = taken ? word.branch : word.next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_FETCH;
      end else begin
         step_ff <= step_in;
      end
   end

   assign ctrl = word;

endmodule

/* design/stbs_dp.sv */
// Search datapath: bounds, probe counter, key table and result register.
// Depends on stbs_pkg, stbs_ram and the assertion macros header.
`include "sorted_table_binary_search_macros.svh"
module stbs_dp #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  stbs_pkg::ctrl_type    ctrl,
   output stbs_pkg::status_type  status,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  stbs_pkg::req_type     req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output stbs_pkg::rsp_type     rsp_payload,
   input  logic                  csr_wr_en,
   input  logic [8:0]            csr_wr_data
);
   import stbs_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int SAT_COUNT = (TABLE_DEPTH < 511) ? TABLE_DEPTH : 511;

   logic [COUNT_WIDTH-1:0]       entry_count_ff;
   logic signed [SPAN_WIDTH-1:0] low_ff, low_in;
   logic signed [SPAN_WIDTH-1:0] high_ff, high_in;
   logic [3:0]                   probes_ff, probes_in;
   logic                         hit_ff, hit_in;
   logic [7:0]                   pos_ff, pos_in;
   logic [15:0]                  want_ff, want_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_type                      rsp_ff, rsp_in;

   logic                   accepted;
   logic                   start;
   logic                   wr_en;
   logic [COUNT_WIDTH-1:0] span;
   logic [SPAN_WIDTH-1:0]  mid_sum;
   logic [COUNT_WIDTH-1:0] mid;
   logic [15:0]            table_key;
   logic                   out_free;
   logic                   finish;

   assign req_ready = ctrl.req_ready;
   assign accepted  = req_valid && ctrl.req_ready;
   assign start     = accepted && ctrl.load && (req_payload.opcode == OP_LOOKUP);
   assign wr_en     = accepted && (req_payload.opcode == OP_WRITE)
                      && (32'(req_payload.entry_index) < TABLE_DEPTH);

   assign span = (entry_count_ff > COUNT_WIDTH'(SAT_COUNT)) ? COUNT_WIDTH'(SAT_COUNT)
                                                           : entry_count_ff;

   assign mid_sum = SPAN_WIDTH'(low_ff[COUNT_WIDTH-1:0]) + SPAN_WIDTH'(high_ff[COUNT_WIDTH-1:0]);
   assign mid     = mid_sum[SPAN_WIDTH-1:1];

   stbs_ram #(
      .WIDTH (16),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_payload.entry_index)),
      .wr_data (req_payload.key),
      .rd_en   (ctrl.read),
      .rd_addr (AW'(mid)),
      .rd_data (table_key)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign finish   = ctrl.finish && out_free;

   assign status.lookup   = start;
   assign status.exhaust  = low_ff > high_ff;
   assign status.match    = table_key == want_ff;
   assign status.out_free = out_free;

   always_comb begin
      low_in    = low_ff;
      high_in   = high_ff;
      probes_in = probes_ff;
      hit_in    = hit_ff;
      pos_in    = pos_ff;
      want_in   = want_ff;
      if (start) begin
         low_in    = '0;
         high_in   = $signed({1'b0, span}) - SPAN_WIDTH'(1);
         probes_in = '0;
         hit_in    = 1'b0;
         pos_in    = '0;
         want_in   = req_payload.key;
      end else if (ctrl.compare) begin
         probes_in = probes_ff + 4'd1;
         if (table_key == want_ff) begin
            hit_in = 1'b1;
            pos_in = mid[7:0];
         end else if (table_key < want_ff) begin
            low_in = $signed({1'b0, mid}) + SPAN_WIDTH'(1);
         end else begin
            high_in = $signed({1'b0, mid}) - SPAN_WIDTH'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (finish) begin
         rsp_valid_in        = 1'b1;
         rsp_in.found        = hit_ff;
         rsp_in.position     = pos_ff;
         rsp_in.probe_count  = probes_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         probes_ff      <= '0;
         hit_ff         <= 1'b0;
         pos_ff         <= '0;
         low_ff         <= '0;
         high_ff        <= '0;
      end else begin
         if (csr_wr_en) begin
            entry_count_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
         probes_ff    <= probes_in;
         hit_ff       <= hit_in;
         pos_ff       <= pos_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
      end
   end

   always_ff @(posedge clock) begin
      want_ff <= want_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `STBS_ASSERT_IMPL(a_compare_in_range, ctrl.compare, low_ff <= high_ff)
   `STBS_ASSERT_IMPL(a_probe_bound, 1'b1, probes_ff <= MAX_PROBES)
   `STBS_ASSERT_IMPL(a_miss_position, rsp_valid_ff && !rsp_ff.found, rsp_ff.position == 8'd0)
   `STBS_ASSERT_NEXT(a_start_clears, start, probes_ff == 4'd0 && !hit_ff)

endmodule

/* design/sorted_table_binary_search.sv */
// Sorted key table with binary search lookup; microcoded sequencer over a plain datapath.
// Write request: taken in the fetch step, no response. Lookup of P probes (at most 9),
// each a table read then a compare; the response is registered in the done step after a
// hit or, on a miss, after the bounds cross; a waiting response stalls the next request.
// Reset (synchronous, active high) clears entry_count, the sequencer and rsp_valid;
// table contents are left as they are and are undefined until written.
module sorted_table_binary_search #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  stbs_pkg::req_type     req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output stbs_pkg::rsp_type     rsp_payload,
   input  logic                  csr_wr_en,
   input  logic [8:0]            csr_wr_data
);
   import stbs_pkg::*;

   ctrl_type   ctrl;
   status_type status;

   stbs_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   stbs_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .status      (status),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

endmodule
